/* hdl/ddo_pkg.sv */
// shared types, constants and helper functions for the differential drive odometry block
// no dependencies
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;

  // q4.30 constants: angles and the cordic gain
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_INV_WHEEL_BASE = 2'd1,
    REG_PERIOD = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic out_free;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/ddo_in_if.sv */
// input channel: valid/ready handshake with update or clear payload
// no dependencies
interface ddo_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic signed [15:0] right_wheel_rate;
  logic signed [15:0] left_wheel_rate;

  modport source (output valid, kind, right_wheel_rate, left_wheel_rate, input ready);
  modport sink (input valid, kind, right_wheel_rate, left_wheel_rate, output ready);
endinterface

/* hdl/ddo_out_if.sv */
// result channel: valid/ready handshake carrying the pose
// no dependencies
interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic signed [31:0] heading;

  modport source (output valid, x_position, y_position, heading, input ready);
  modport sink (input valid, x_position, y_position, heading, output ready);
endinterface

/* hdl/ddo_core.sv */
// odometry sequencer around one shared multiplier, range reduction and cordic
// depends on ddo_pkg
module ddo_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  ddo_pkg::core_ctrl_t ctrl,
  input  logic signed [15:0] right_rate,
  input  logic signed [15:0] left_rate,
  input  logic [15:0] radius_q,
  input  logic [15:0] inv_wheel_base,
  input  logic [15:0] period_q,
  output ddo_pkg::core_stat_t stat,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] pose_heading
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);
  localparam logic [3:0] RED_TOP = 4'd13;
  localparam logic signed [47:0] Q_TWO_PI48 = 48'(ddo_pkg::Q30_TWO_PI);

  typedef enum logic [3:0] {
    S_IDLE, S_VR, S_VL, S_YAW, S_DH, S_RED0, S_RED, S_FOLD,
    S_CORD, S_XR, S_YR, S_PX, S_PY, S_DONE
  } state_t;

  state_t state_r;
  logic signed [15:0] rr_r, lr_r;
  logic signed [24:0] vr_r, vl_r;
  logic signed [31:0] yaw_r, xr_r, yr_r;
  logic signed [31:0] px_r, py_r, hd_r, lx_r, ly_r, lyaw_r;
  logic signed [47:0] rz_r;
  logic [3:0] k_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [IW-1:0] it_r;
  logic neg_r;
  logic done_r;

  // shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [25:0] vsum, vdiff;
  logic signed [24:0] speed;
  logic signed [33:0] cosv, sinv;

  assign vsum = 26'(vr_r) + 26'(vl_r);
  assign vdiff = 26'(vr_r) - 26'(vl_r);
  assign speed = vsum[25:1];
  assign cosv = neg_r ? -cx_r : cx_r;
  assign sinv = neg_r ? -cy_r : cy_r;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_VR: begin ma = 34'(rr_r); mb = {18'd0, radius_q}; end
      S_VL: begin ma = 34'(lr_r); mb = {18'd0, radius_q}; end
      S_YAW: begin ma = 34'(vdiff); mb = {18'd0, inv_wheel_base}; end
      S_DH: begin ma = 34'(yaw_r) + 34'(lyaw_r); mb = {18'd0, period_q}; end
      S_XR: begin ma = 34'(speed); mb = cosv; end
      S_YR: begin ma = 34'(speed); mb = sinv; end
      S_PX: begin ma = 34'(xr_r) + 34'(lx_r); mb = {18'd0, period_q}; end
      S_PY: begin ma = 34'(yr_r) + 34'(ly_r); mb = {18'd0, period_q}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  // range reduction and fold helpers
  logic signed [47:0] red_step;
  logic signed [33:0] fz0, fz1;
  logic fneg;
  logic signed [67:0] pstep;

  assign red_step = Q_TWO_PI48 <<< k_r;
  assign pstep = prod >>> 17;

  always_comb begin
    fz0 = rz_r[33:0];
    if (fz0 > ddo_pkg::Q30_PI) begin
      fz0 = fz0 - ddo_pkg::Q30_TWO_PI;
    end
    fz1 = fz0;
    fneg = 1'b0;
    if (fz0 > ddo_pkg::Q30_HALF_PI) begin
      fz1 = fz0 - ddo_pkg::Q30_PI;
      fneg = 1'b1;
    end else if (fz0 < -ddo_pkg::Q30_HALF_PI) begin
      fz1 = fz0 + ddo_pkg::Q30_PI;
      fneg = 1'b1;
    end
  end

  // cordic micro-rotation
  logic signed [33:0] sx, sy, at;
  assign sx = cx_r >>> it_r;
  assign sy = cy_r >>> it_r;
  assign at = ddo_pkg::atan_q30(5'(it_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
      px_r <= '0; py_r <= '0; hd_r <= '0;
      lx_r <= '0; ly_r <= '0; lyaw_r <= '0;
      it_r <= '0; k_r <= '0; neg_r <= 1'b0;
    end else begin
      done_r <= (state_r == S_DONE) && ctrl.out_free;
      unique case (state_r)
        S_IDLE: begin
          if (ctrl.start) begin
            rr_r <= right_rate;
            lr_r <= left_rate;
            if (ctrl.clear) begin
              px_r <= '0; py_r <= '0; hd_r <= '0;
              lx_r <= '0; ly_r <= '0; lyaw_r <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_VR;
            end
          end
        end
        S_VR: begin vr_r <= prod[32:8]; state_r <= S_VL; end
        S_VL: begin vl_r <= prod[32:8]; state_r <= S_YAW; end
        S_YAW: begin yaw_r <= ddo_pkg::sat32(prod >>> 8); state_r <= S_DH; end
        S_DH: begin hd_r <= hd_r + pstep[31:0]; state_r <= S_RED0; end
        S_RED0: begin
          // to q18.30, shifted nonnegative by a multiple of two pi
          if (hd_r[31]) begin
            rz_r <= (48'(hd_r) <<< 14) + (Q_TWO_PI48 <<< 13);
          end else begin
            rz_r <= 48'(hd_r) <<< 14;
          end
          k_r <= RED_TOP;
          state_r <= S_RED;
        end
        S_RED: begin
          if (rz_r >= red_step) begin
            rz_r <= rz_r - red_step;
          end
          k_r <= k_r - 4'd1;
          if (k_r == 4'd0) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          cz_r <= fz1;
          neg_r <= fneg;
          cx_r <= ddo_pkg::Q30_GAIN;
          cy_r <= '0;
          it_r <= '0;
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - sy;
            cy_r <= cy_r + sx;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + sy;
            cy_r <= cy_r - sx;
            cz_r <= cz_r + at;
          end
          it_r <= it_r + 1'b1;
          if (it_r == LAST_ITER) begin
            state_r <= S_XR;
          end
        end
        S_XR: begin xr_r <= ddo_pkg::sat32(prod >>> 30); state_r <= S_YR; end
        S_YR: begin yr_r <= ddo_pkg::sat32(prod >>> 30); state_r <= S_PX; end
        S_PX: begin
          px_r <= ddo_pkg::sat32(68'(px_r) + pstep);
          lx_r <= xr_r;
          state_r <= S_PY;
        end
        S_PY: begin
          py_r <= ddo_pkg::sat32(68'(py_r) + pstep);
          ly_r <= yr_r;
          lyaw_r <= yaw_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the result register can take the pose
          if (ctrl.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;
  assign pose_x = px_r;
  assign pose_y = py_r;
  assign pose_heading = hd_r;

endmodule

/* hdl/differential_drive_odometry_top.sv */
// one beat in flight: a new update or clear beat is taken only once the sequencer is back in idle,
// so an input beat can wait while the result register is still full
// the cordic loop (one micro-rotation per cycle) and the 14-step angle reduction take the longest
// reset (rst_n, synchronous, active low) zeroes the pose, rate history, configuration and control state
// depends on ddo_pkg, ddo_in_if, ddo_out_if, ddo_core
module differential_drive_odometry_top #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ddo_in_if.sink in_ch,
  ddo_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [15:0] radius_r, inv_base_r, cyc_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      inv_base_r <= '0;
      cyc_t_r <= '0;
    end else if (cfg_we) begin
      unique case (ddo_pkg::reg_idx_t'(cfg_index))
        ddo_pkg::REG_RADIUS: radius_r <= cfg_wdata;
        ddo_pkg::REG_INV_WHEEL_BASE: inv_base_r <= cfg_wdata;
        ddo_pkg::REG_PERIOD: cyc_t_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input beat goes straight into the sequencer when it is idle
  ddo_pkg::core_ctrl_t core_ctrl;
  ddo_pkg::core_stat_t core_st;
  logic in_take;
  logic out_valid_r;
  logic signed [31:0] cx_pose, cy_pose, ch_pose;

  assign in_ch.ready = !core_st.busy;
  assign in_take = in_ch.valid && in_ch.ready;

  assign core_ctrl.start = in_take;
  assign core_ctrl.clear = (in_ch.kind == ddo_pkg::KIND_CLEAR);
  // result register frees up when empty or being drained this cycle
  assign core_ctrl.out_free = !out_valid_r || out_ch.ready;

  ddo_core #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .ctrl(core_ctrl),
    .right_rate(in_ch.right_wheel_rate),
    .left_rate(in_ch.left_wheel_rate),
    .radius_q(radius_r),
    .inv_wheel_base(inv_base_r),
    .period_q(cyc_t_r),
    .stat(core_st),
    .pose_x(cx_pose),
    .pose_y(cy_pose),
    .pose_heading(ch_pose)
  );

  // output register: holds one pose beat so the sequencer can take the next input
  logic signed [31:0] ox_r, oy_r, oh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (core_st.done) begin
        out_valid_r <= 1'b1;
        ox_r <= cx_pose;
        oy_r <= cy_pose;
        oh_r <= ch_pose;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.x_position = ox_r;
  assign out_ch.y_position = oy_r;
  assign out_ch.heading = oh_r;

`ifndef NO_ASSERTIONS
  // an accepted beat makes the sequencer busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ch.ready)
    else $error("sequencer not busy after accepted beat");

  // the sequencer only finishes into a free result register
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    core_st.done |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten before it was taken");

  // a finished beat always shows up on the result channel
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    core_st.done |=> out_valid_r)
    else $error("finished beat not presented");
`endif

endmodule
